[design/pds_pkg.sv]
// Package for the PLL divider search block.
// Holds field widths, search constants, the sequencer state type and the
// structs shared by the top level and the search core. No dependencies.
package pds_pkg;

  localparam int unsigned M_MAX = 127;
  localparam int unsigned P_MAX = 3;

  localparam int unsigned IN_W    = 20;
  localparam int unsigned REF_W   = 16;
  localparam int unsigned NOUT_W  = 7;
  localparam int unsigned MOUT_W  = 7;
  localparam int unsigned PP_W    = 2;
  localparam int unsigned S_DATA_W = 24;
  localparam int unsigned M_DATA_W = 16;

  localparam int unsigned F_W     = 18;
  localparam int unsigned NP_W    = 8;
  localparam int unsigned N_W     = 8;
  localparam int unsigned Q_W     = $clog2(M_MAX + 3);
  localparam int unsigned CNT_W   = $clog2(Q_W);
  localparam int unsigned KA_W    = $clog2(8 * (M_MAX + 2) + 1);
  localparam int unsigned A_W     = KA_W + REF_W;
  localparam int unsigned B_W     = F_W + NP_W;
  localparam int unsigned DEN_W   = REF_W + NP_W;
  localparam int unsigned X_W     = B_W + 2;
  localparam int unsigned DV_W    = REF_W + 4 + Q_W;
  localparam int unsigned CMP_W   = (X_W > DV_W) ? X_W : DV_W;
  localparam int unsigned LIM_W   = 17;
  localparam int unsigned MA_W    = (A_W > F_W) ? A_W : F_W;
  localparam int unsigned MB_W    = DEN_W;
  localparam int unsigned PR_W    = MA_W + MB_W;

  localparam logic [IN_W-1:0]  F_LOW      = IN_W'(12000);
  localparam logic [IN_W-1:0]  F_HIGH     = IN_W'(220000);
  localparam logic [F_W-1:0]   F_VCO_MIN  = F_W'(110000);
  localparam logic [REF_W-1:0] REF_RESET  = REF_W'(14318);
  localparam logic [N_W-1:0]   N_LIMIT    = N_W'(127);
  localparam logic [LIM_W-1:0] LIM_FIRST  = LIM_W'(1500);
  localparam logic [LIM_W-1:0] LIM_STEP   = LIM_W'(500);
  localparam logic [NOUT_W-1:0] DEFAULT_N = NOUT_W'(32);
  localparam logic [Q_W-1:0]   DEFAULT_M  = Q_W'(32);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DINIT,
    ST_DIV,
    ST_MSET,
    ST_MUL_A,
    ST_ABS,
    ST_MUL_L,
    ST_MUL_R,
    ST_CMP,
    ST_DONE
  } pds_state_e;

  typedef struct packed {
    logic [F_W-1:0]  f;
    logic [PP_W-1:0] p;
  } job_t;

  typedef struct packed {
    logic [PP_W-1:0]   p;
    logic [MOUT_W-1:0] m;
    logic [NOUT_W-1:0] n;
  } res_t;

endpackage

[design/pll_divider_search.sv]
// Top level of the PLL divider search: stream ports, reference register,
// target clamp and post divider choice, result output register.
// Depends on pds_pkg and pds_seq.
//
//   Channel   Direction  Signals                                  Content
//   s_axis    in         s_axis_tvalid/tready/tdata               target request
//   m_axis    out        m_axis_tvalid/tready/tdata               n, m, p result
//   cfg       in         cfg_valid_i/cfg_ready_o/cfg_data_i       reference in kHz
//
// A request tries N = min(floor(ref / 500) - 2, 127) n values (N = 0 below
// 1500 kHz); each n takes eight divider steps for m, skipped when the quotient saturates,
// and three passes through the shared multiplier for the error compare.
// Reset puts the reference at 14318 kHz; no memory is cleared.
// A new request is taken while an earlier result waits at m_axis; the core
// holds its result until the output register is free.
module pll_divider_search import pds_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,   // [19:0] target_freq_khz
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [M_DATA_W-1:0] m_axis_tdata,   // [6:0] n_div, [13:7] m_mult, [15:14] p_post
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [REF_W-1:0]    cfg_data_i
);

  logic [REF_W-1:0] ref_q;
  logic             out_valid_q;
  res_t             out_q;
  logic [IN_W-1:0]  f_clamp;
  logic [F_W-1:0]   f_work;
  logic [PP_W-1:0]  p_work;
  job_t             job;
  logic             core_ready;
  logic             res_valid;
  logic             res_ready;
  res_t             res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= REF_RESET;
    end else if (cfg_valid_i) begin
      ref_q <= cfg_data_i;
    end
  end

  always_comb begin
    f_clamp = s_axis_tdata[IN_W-1:0];
    if (f_clamp < F_LOW) begin
      f_clamp = F_LOW;
    end else if (f_clamp > F_HIGH) begin
      f_clamp = F_HIGH;
    end
    f_work = f_clamp[F_W-1:0];
    p_work = '0;
    for (int i = 0; i < int'(P_MAX); i++) begin
      if (f_work < F_VCO_MIN) begin
        f_work = f_work << 1;
        p_work = p_work + PP_W'(1);
      end
    end
  end

  assign job.f = f_work;
  assign job.p = p_work;

  pds_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (s_axis_tvalid),
    .job_i       (job),
    .ready_o     (core_ready),
    .ref_i       (ref_q),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  assign s_axis_tready = core_ready;
  assign res_ready     = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_DATA_W'(out_q);

endmodule

[design/pds_mul.sv]
// Shared multiplier of the divider search with a registered product.
// Depends on pds_pkg for operand and product widths.
module pds_mul import pds_pkg::*; (
  input  logic            clk_i,
  input  logic [MA_W-1:0] a_i,
  input  logic [MB_W-1:0] b_i,
  output logic [PR_W-1:0] prod_o
);

  logic [PR_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PR_W'(a_i) * PR_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

[design/pds_seq.sv]
// Search core: sequencer over n with a bit-serial divider for m and the
// shared multiplier for the error cross-products.
// Depends on pds_pkg and pds_mul.
module pds_seq import pds_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  input  job_t             job_i,
  output logic             ready_o,
  input  logic [REF_W-1:0] ref_i,
  output logic             res_valid_o,
  output res_t             res_o,
  input  logic             res_ready_i
);

  pds_state_e state_q, state_d;

  logic [F_W-1:0]    f_q;
  logic [PP_W-1:0]   p_q;
  logic [N_W-1:0]    n_q;
  logic [B_W-1:0]    b_q;
  logic [DEN_W-1:0]  den_q;
  logic [LIM_W-1:0]  lim_q;
  logic [X_W-1:0]    rem_q;
  logic [DV_W-1:0]   div_q;
  logic [Q_W-1:0]    q_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [Q_W-1:0]    m_q;
  logic [A_W-1:0]    d_q;
  logic [PR_W-1:0]   lhs_q;
  logic [MA_W-1:0]   best_num_q;
  logic [DEN_W-1:0]  best_den_q;
  logic [NOUT_W-1:0] best_n_q;
  logic [Q_W-1:0]    best_m_q;

  logic [MA_W-1:0]   mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [PR_W-1:0]   prod;
  logic [X_W-1:0]    x_init;
  logic              sat;
  logic              rem_ge;
  logic [A_W-1:0]    a_val;
  logic [A_W-1:0]    b_ext;
  logic [Q_W-1:0]    m_clamp;

  pds_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign x_init = (X_W'(b_q) << 1) + (X_W'(ref_i) << 3);
  assign sat    = CMP_W'(x_init) >= (CMP_W'(ref_i) << (Q_W + 4));
  assign rem_ge = CMP_W'(rem_q) >= CMP_W'(div_q);
  assign a_val  = prod[A_W-1:0];
  assign b_ext  = A_W'(b_q);

  always_comb begin
    if (q_q < Q_W'(3)) begin
      m_clamp = Q_W'(1);
    end else begin
      m_clamp = q_q - Q_W'(2);
    end
    if (m_clamp > Q_W'(M_MAX)) begin
      m_clamp = Q_W'(M_MAX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ready_o     = 1'b0;
    res_valid_o = 1'b0;
    mul_a       = MA_W'({Q_W'(m_q + Q_W'(2)), 3'b000});
    mul_b       = MB_W'(ref_i);
    unique case (state_q)
      ST_IDLE: begin
        ready_o = 1'b1;
        if (job_valid_i) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (n_q > N_LIMIT || lim_q > LIM_W'(ref_i)) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_DINIT;
        end
      end
      ST_DINIT: begin
        state_d = sat ? ST_MSET : ST_DIV;
      end
      ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = ST_MSET;
        end
      end
      ST_MSET: begin
        state_d = ST_MUL_A;
      end
      ST_MUL_A: begin
        state_d = ST_ABS;
      end
      ST_ABS: begin
        state_d = ST_MUL_L;
      end
      ST_MUL_L: begin
        mul_a   = MA_W'(d_q);
        mul_b   = best_den_q;
        state_d = ST_MUL_R;
      end
      ST_MUL_R: begin
        mul_a   = best_num_q;
        mul_b   = den_q;
        state_d = ST_CMP;
      end
      ST_CMP: begin
        state_d = ST_CHECK;
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          f_q        <= job_i.f;
          p_q        <= job_i.p;
          n_q        <= N_W'(1);
          b_q        <= B_W'(job_i.f) + (B_W'(job_i.f) << 1);
          den_q      <= DEN_W'(ref_i) + (DEN_W'(ref_i) << 1);
          lim_q      <= LIM_FIRST;
          best_num_q <= MA_W'(job_i.f);
          best_den_q <= DEN_W'(ref_i);
          best_n_q   <= DEFAULT_N;
          best_m_q   <= DEFAULT_M;
        end
      end
      ST_DINIT: begin
        rem_q <= x_init;
        div_q <= DV_W'(ref_i) << (Q_W + 3);
        cnt_q <= CNT_W'(Q_W - 1);
        q_q   <= sat ? '1 : '0;
      end
      ST_DIV: begin
        if (rem_ge) begin
          rem_q <= rem_q - X_W'(div_q);
        end
        q_q   <= {q_q[Q_W-2:0], rem_ge};
        div_q <= div_q >> 1;
        cnt_q <= cnt_q - CNT_W'(1);
      end
      ST_MSET: begin
        m_q <= m_clamp;
      end
      ST_ABS: begin
        d_q <= (a_val > b_ext) ? (a_val - b_ext) : (b_ext - a_val);
      end
      ST_MUL_R: begin
        lhs_q <= prod;
      end
      ST_CMP: begin
        if (lhs_q < prod) begin
          best_num_q <= MA_W'(d_q);
          best_den_q <= den_q;
          best_n_q   <= n_q[NOUT_W-1:0];
          best_m_q   <= m_q;
        end
        n_q   <= n_q + N_W'(1);
        b_q   <= b_q + B_W'(f_q);
        den_q <= den_q + DEN_W'(ref_i);
        lim_q <= lim_q + LIM_STEP;
      end
      default: begin
      end
    endcase
  end

  assign res_o.n = best_n_q;
  assign res_o.m = best_m_q[MOUT_W-1:0];
  assign res_o.p = p_q;

endmodule

[verif/pds_checker.sv]
// Checker for the PLL divider search: watches the request, result and
// reference write channels, predicts each result and compares it field by field.
// Depends on pds_pkg for widths, limits and the packed result type.
module pds_checker import pds_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [M_DATA_W-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_o,
  input  logic [REF_W-1:0]    cfg_data_i,
  output int                  mismatch_count,
  output int                  results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned KHZ_PER_N = 500;

  logic [REF_W-1:0] ref_khz;
  res_t             expected_divs[$];

  initial mismatch_count = 0;
  initial results_owed = 0;

  function automatic res_t search_dividers(logic [IN_W-1:0] target, logic [REF_W-1:0] refk);
    longint unsigned f, r, p, best_n, best_m, best_num, best_den, n_top;
    longint unsigned m_raw, m, a, b, d, den;
    res_t            pick;
    f = target;
    r = refk;
    p = 0;
    best_n = DEFAULT_N;
    best_m = DEFAULT_M;
    n_top = 0;
    if (f < F_LOW) begin
      f = F_LOW;
    end else if (f > F_HIGH) begin
      f = F_HIGH;
    end
    while (p < P_MAX && f < F_VCO_MIN) begin
      f = f << 1;
      p++;
    end
    best_num = f;
    best_den = r;
    if (r / KHZ_PER_N > 2) begin
      n_top = r / KHZ_PER_N - 2;
    end
    if (n_top > N_LIMIT) begin
      n_top = N_LIMIT;
    end
    for (longint unsigned n = 1; n <= n_top; n++) begin
      m_raw = (2 * f * (n + 2) + 8 * r) / (16 * r);
      m = (m_raw < 3) ? 1 : m_raw - 2;
      if (m > M_MAX) begin
        m = M_MAX;
      end
      a = 8 * (m + 2) * r;
      b = f * (n + 2);
      d = (a > b) ? a - b : b - a;
      den = r * (n + 2);
      if (d * best_den < best_num * den) begin
        best_num = d;
        best_den = den;
        best_n = n;
        best_m = m;
      end
    end
    pick.n = NOUT_W'(best_n);
    pick.m = MOUT_W'(best_m);
    pick.p = PP_W'(p);
    return pick;
  endfunction

  task automatic report(string what, int unsigned want, int unsigned got);
    $display("%0t: mismatch in %s: expected %0d, got %0d", $realtime, what, want, got);
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t got;
    res_t want;
    if (!rst_ni) begin
      ref_khz = REF_RESET;
      expected_divs.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        ref_khz = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_divs.push_back(search_dividers(s_axis_tdata[IN_W-1:0], ref_khz));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = res_t'(m_axis_tdata);
        if (expected_divs.size() == 0) begin
          report("result without request", 0, m_axis_tdata);
        end else begin
          want = expected_divs.pop_front();
          if (got.n !== want.n) report("n_div", want.n, got.n);
          if (got.m !== want.m) report("m_mult", want.m, got.m);
          if (got.p !== want.p) report("p_post", want.p, got.p);
        end
      end
    end
    results_owed = expected_divs.size();
  end

endmodule

[verif/tb.sv]
// Testbench top for the PLL divider search: drives target requests and
// reference writes under several pacing modes and gives the verdict.
// Depends on pds_pkg, pll_divider_search and pds_checker.
module tb;
  import pds_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_e;

  localparam int CYCLE_LIMIT = 3000000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [REF_W-1:0]    cfg_data_i = '0;
  int                  mismatch_count;
  int                  results_owed;

  pace_e pace = PACE_FULL;
  bit    long_hold_req = 1'b0;
  bit    long_hold_done = 1'b0;
  int    hold_left = 0;
  int    cycle_count = 0;

  logic [IN_W-1:0] corner_targets [20] = '{
    0, 1, 11999, 12000, 12001, 13749, 13750, 27499, 27500, 54999,
    55000, 109999, 110000, 150000, 219999, 220000, 220001,
    20'h55555, 20'hAAAAA, 20'hFFFFF
  };
  int unsigned band_edges [6] = '{12000, 13750, 27500, 55000, 110000, 220000};

  pll_divider_search dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  pds_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // The long hold lets the block fill up and push back on new requests.
  always @(posedge clk_i) begin
    if (long_hold_req && !long_hold_done) begin
      hold_left = 600;
      long_hold_done = 1'b1;
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (pace)
        PACE_RECV_STALLS: m_axis_tready <= ($urandom_range(0, 99) >= 46);
        PACE_BOTH:        m_axis_tready <= ($urandom_range(0, 99) >= 9);
        default:          m_axis_tready <= 1'b1;
      endcase
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  function automatic bit sender_waits();
    case (pace)
      PACE_SEND_GAPS: return $urandom_range(0, 99) < 46;
      PACE_BOTH:      return $urandom_range(0, 99) < 9;
      default:        return 1'b0;
    endcase
  endfunction

  function automatic logic [IN_W-1:0] pick_target();
    case ($urandom_range(0, 9))
      6:       return IN_W'(band_edges[$urandom_range(0, 5)] + $urandom_range(0, 2) - 1);
      7:       return IN_W'($urandom_range(0, 11999));
      8:       return IN_W'($urandom);
      9:       return IN_W'($urandom_range(220001, 1048575));
      default: return IN_W'($urandom_range(12000, 220000));
    endcase
  endfunction

  // Called right after a rising edge; returns right after the edge that
  // accepted the request.
  task automatic push_request(logic [IN_W-1:0] target);
    while (sender_waits()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= S_DATA_W'(target);
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (results_owed != 0);
    @(posedge clk_i);
  endtask

  task automatic write_ref_khz(logic [REF_W-1:0] value);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(logic [REF_W-1:0] ref_value, int count, pace_e mode);
    write_ref_khz(ref_value);
    pace = mode;
    for (int i = 0; i < count; i++) begin
      if (count >= 40 && i == count / 2) begin
        wait_all_results();
      end
      push_request(pick_target());
    end
    wait_all_results();
    pace = PACE_FULL;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_targets[i]) begin
      push_request(corner_targets[i]);
    end
    wait_all_results();

    run_phase(16'd0, 100, PACE_SEND_GAPS);
    run_phase(16'hFFFF, 12, PACE_RECV_STALLS);
    run_phase(16'd50000, 12, PACE_BOTH);
    long_hold_req = 1'b1;
    run_phase(16'd1000, 100, PACE_FULL);
    run_phase(REF_W'($urandom_range(1, 1499)), 60, PACE_RECV_STALLS);
    run_phase(16'd1500, 50, PACE_BOTH);
    for (int k = 0; k < 9; k++) begin
      run_phase(REF_W'($urandom_range(1000, 8000)), 110, pace_e'(k % 4));
    end
    run_phase(REF_W'($urandom_range(0, 65535)), 20, PACE_BOTH);

    repeat (100) @(posedge clk_i);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
